>>> rtl/core/lus_pkg.sv
`default_nettype none
package lus_pkg;

	localparam int ORDER     = 3;
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int SLOT_W    = 4;
	localparam int UIDX_W    = 2;
	localparam int PROD_W    = 2 * WORD_W;

	// memory map of the single working store
	localparam int MAT_SIZE  = ORDER * ORDER;
	localparam int BASE_COEF = 0;
	localparam int BASE_RHS  = BASE_COEF + MAT_SIZE;
	localparam int BASE_L    = BASE_RHS + ORDER;
	localparam int BASE_U    = BASE_L + MAT_SIZE;
	localparam int BASE_Y    = BASE_U + MAT_SIZE;
	localparam int BASE_X    = BASE_Y + ORDER;
	localparam int MEM_DEPTH = BASE_X + ORDER;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int CNT_W     = $clog2(ORDER + 1);
	localparam int DIV_BITS  = WORD_W + FRAC_BITS;
	localparam int DCNT_W    = $clog2(DIV_BITS + 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0]        addr_t;

	typedef struct packed {
		logic  ovf;
		word_t val;
	} sat_t;

	typedef enum logic [12:0] {
		ST_IDLE = 13'h0001,
		ST_INIT = 13'h0002,
		ST_LOAD = 13'h0004,
		ST_RD   = 13'h0008,
		ST_MUL  = 13'h0010,
		ST_ACC  = 13'h0020,
		ST_DVS  = 13'h0040,
		ST_DIV  = 13'h0080,
		ST_DVF  = 13'h0100,
		ST_WR   = 13'h0200,
		ST_ERD  = 13'h0400,
		ST_ELD  = 13'h0800,
		ST_EWT  = 13'h1000
	} state_t;

	typedef enum logic [1:0] {
		PH_L = 2'd0,
		PH_U = 2'd1,
		PH_Y = 2'd2,
		PH_X = 2'd3
	} phase_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	function automatic addr_t addr_of(input int base, input int row, input int col);
		return ADDR_W'(base + row * ORDER + col);
	endfunction

	// floor shift of the full product, then clamp to one word
	function automatic sat_t sat_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		sat_t                     o;
		r = p >>> FRAC_BITS;
		if ((r[PROD_W-1:WORD_W-1] == '0) || (r[PROD_W-1:WORD_W-1] == '1)) begin
			o.ovf = 1'b0;
			o.val = r[WORD_W-1:0];
		end else begin
			o.ovf = 1'b1;
			o.val = r[PROD_W-1] ? WORD_MIN : WORD_MAX;
		end
		return o;
	endfunction

	function automatic sat_t sub_sat(input word_t a, input word_t b);
		logic signed [WORD_W:0] d;
		sat_t                   o;
		d = (WORD_W+1)'(a) - (WORD_W+1)'(b);
		if (d[WORD_W] == d[WORD_W-1]) begin
			o.ovf = 1'b0;
			o.val = d[WORD_W-1:0];
		end else begin
			o.ovf = 1'b1;
			o.val = d[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return o;
	endfunction

	function automatic logic [WORD_W-1:0] mag(input word_t v);
		return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/lus_ram.sv
`default_nettype none
module lus_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

>>> rtl/core/lu_solve_3x3.sv
`default_nettype none
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    slot, value, solve_req
// out       output     out_valid / out_ready  unknown_index, solution, last, singular, overflow
//
// a store request is written as it is taken; loads may arrive back to back
// a solve request runs the whole factor and solve on one shared multiply-accumulate
// and one radix-2 divider (32+FRAC_BITS quotient bits per division), all through the
// two-read, one-write working memory: each element runs init, load, read, multiply
// and accumulate per term, divide where needed, write; each solution is read, then shown
// in_ready is low from the solve request until the last solution is taken
// asynchronous reset clears control only; stores are undefined until written
module lu_solve_3x3 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lus_pkg::SLOT_W-1:0]   slot,
	input  wire logic signed [lus_pkg::WORD_W-1:0] value,
	input  wire logic                         solve_req,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [lus_pkg::UIDX_W-1:0]        unknown_index,
	output logic signed [lus_pkg::WORD_W-1:0] solution,
	output logic                              last,
	output logic                              singular,
	output logic                              overflow
);

	localparam logic [lus_pkg::CNT_W-1:0] LAST_IDX = lus_pkg::CNT_W'(lus_pkg::ORDER - 1);

	lus_pkg::state_t st_q;
	lus_pkg::phase_t ph_q;
	logic [lus_pkg::CNT_W-1:0] k_q, r_q, s_q, e_q;
	logic [lus_pkg::DCNT_W-1:0] dcnt_q;
	logic sing_q, ovf_q, out_valid_q;

	lus_pkg::word_t acc_q, piv_q;
	logic signed [lus_pkg::PROD_W-1:0] prod_s2;
	logic [lus_pkg::DIV_BITS-1:0] dvd_q;
	logic [lus_pkg::WORD_W-1:0] rem_q, dsr_q;
	logic neg_q;
	logic [lus_pkg::UIDX_W-1:0] uidx_q;
	lus_pkg::word_t sol_q;
	logic last_q;

	// memory port signals
	logic           we;
	lus_pkg::addr_t waddr, raddr_a, raddr_b;
	lus_pkg::word_t wdata, rdata_a, rdata_b;

	logic in_acc;
	assign in_ready = (st_q == lus_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// per-element addressing, chosen by phase
	lus_pkg::addr_t init_addr, piv_addr, ta_addr, tb_addr, tgt_addr;
	logic [lus_pkg::CNT_W-1:0] s_start, s_lim;
	logic use_div;
	int ki, ri, si;

	always_comb begin
		ki = int'(k_q);
		ri = int'(r_q);
		si = int'(s_q);
		init_addr = '0;
		piv_addr  = lus_pkg::addr_of(lus_pkg::BASE_L, ri, ri);
		ta_addr   = '0;
		tb_addr   = '0;
		tgt_addr  = '0;
		s_start   = '0;
		s_lim     = '0;
		use_div   = 1'b0;
		case (ph_q)
			lus_pkg::PH_L: begin
				// lower column k, row r
				init_addr = lus_pkg::addr_of(lus_pkg::BASE_COEF, ri, ki);
				ta_addr   = lus_pkg::addr_of(lus_pkg::BASE_L, ri, si);
				tb_addr   = lus_pkg::addr_of(lus_pkg::BASE_U, si, ki);
				tgt_addr  = lus_pkg::addr_of(lus_pkg::BASE_L, ri, ki);
				s_lim     = k_q;
			end
			lus_pkg::PH_U: begin
				// upper row k, column r, divided by the row pivot
				init_addr = lus_pkg::addr_of(lus_pkg::BASE_COEF, ki, ri);
				piv_addr  = lus_pkg::addr_of(lus_pkg::BASE_L, ki, ki);
				ta_addr   = lus_pkg::addr_of(lus_pkg::BASE_L, ki, si);
				tb_addr   = lus_pkg::addr_of(lus_pkg::BASE_U, si, ri);
				tgt_addr  = lus_pkg::addr_of(lus_pkg::BASE_U, ki, ri);
				s_lim     = k_q;
				use_div   = 1'b1;
			end
			lus_pkg::PH_Y: begin
				// forward substitution
				init_addr = lus_pkg::addr_of(lus_pkg::BASE_RHS, 0, ri);
				ta_addr   = lus_pkg::addr_of(lus_pkg::BASE_L, ri, si);
				tb_addr   = lus_pkg::addr_of(lus_pkg::BASE_Y, 0, si);
				tgt_addr  = lus_pkg::addr_of(lus_pkg::BASE_Y, 0, ri);
				s_lim     = r_q;
				use_div   = 1'b1;
			end
			default: begin
				// back substitution, unit diagonal
				init_addr = lus_pkg::addr_of(lus_pkg::BASE_Y, 0, ri);
				ta_addr   = lus_pkg::addr_of(lus_pkg::BASE_U, ri, si);
				tb_addr   = lus_pkg::addr_of(lus_pkg::BASE_X, 0, si);
				tgt_addr  = lus_pkg::addr_of(lus_pkg::BASE_X, 0, ri);
				s_start   = r_q + lus_pkg::CNT_W'(1);
				s_lim     = lus_pkg::CNT_W'(lus_pkg::ORDER);
			end
		endcase
	end

	// read port selection
	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		if (st_q == lus_pkg::ST_INIT) begin
			raddr_a = init_addr;
			raddr_b = piv_addr;
		end else if (st_q == lus_pkg::ST_RD) begin
			raddr_a = ta_addr;
			raddr_b = tb_addr;
		end else if (st_q == lus_pkg::ST_ERD) begin
			raddr_a = lus_pkg::addr_of(lus_pkg::BASE_X, 0, int'(e_q));
		end
	end

	// write port: stores from the input side, results from the sequencer
	always_comb begin
		if (st_q == lus_pkg::ST_WR) begin
			we    = 1'b1;
			waddr = tgt_addr;
			wdata = acc_q;
		end else begin
			we    = in_acc &&
				(slot < lus_pkg::SLOT_W'(lus_pkg::MAT_SIZE + lus_pkg::ORDER));
			waddr = lus_pkg::ADDR_W'(slot);
			wdata = value;
		end
	end

	lus_ram #(
		.WIDTH(lus_pkg::WORD_W),
		.DEPTH(lus_pkg::MEM_DEPTH)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	// multiply-subtract step
	lus_pkg::sat_t term, diff;
	assign term = lus_pkg::sat_prod(prod_s2);
	assign diff = lus_pkg::sub_sat(acc_q, term.val);

	logic [lus_pkg::CNT_W-1:0] s_nxt;
	assign s_nxt = s_q + lus_pkg::CNT_W'(1);

	// one quotient bit per cycle
	logic [lus_pkg::WORD_W:0]   rem_sh;
	logic                       q_bit;
	logic [lus_pkg::WORD_W-1:0] rem_nxt;
	always_comb begin
		rem_sh = {rem_q, dvd_q[lus_pkg::DIV_BITS-1]};
		q_bit  = (rem_sh >= {1'b0, dsr_q});
		if (q_bit) begin
			rem_nxt = lus_pkg::WORD_W'(rem_sh - {1'b0, dsr_q});
		end else begin
			rem_nxt = rem_sh[lus_pkg::WORD_W-1:0];
		end
	end

	// sign and clamp of the quotient magnitude
	logic [lus_pkg::FRAC_BITS:0] q_hi;
	logic                        dvf_ovf;
	lus_pkg::word_t              dvf_val;
	always_comb begin
		q_hi = dvd_q[lus_pkg::DIV_BITS-1:lus_pkg::WORD_W-1];
		if (neg_q) begin
			dvf_ovf = (q_hi > (lus_pkg::FRAC_BITS+1)'(1)) ||
				((q_hi == (lus_pkg::FRAC_BITS+1)'(1)) &&
				(dvd_q[lus_pkg::WORD_W-2:0] != '0));
			dvf_val = dvf_ovf ? lus_pkg::WORD_MIN : -$signed(dvd_q[lus_pkg::WORD_W-1:0]);
		end else begin
			dvf_ovf = (q_hi != '0);
			dvf_val = dvf_ovf ? lus_pkg::WORD_MAX : $signed(dvd_q[lus_pkg::WORD_W-1:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lus_pkg::ST_IDLE;
			ph_q        <= lus_pkg::PH_L;
			k_q         <= '0;
			r_q         <= '0;
			s_q         <= '0;
			e_q         <= '0;
			dcnt_q      <= '0;
			sing_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				lus_pkg::ST_IDLE: begin
					if (in_acc && solve_req) begin
						sing_q <= 1'b0;
						ovf_q  <= 1'b0;
						ph_q   <= lus_pkg::PH_L;
						k_q    <= '0;
						r_q    <= '0;
						st_q   <= lus_pkg::ST_INIT;
					end
				end
				lus_pkg::ST_INIT: begin
					s_q  <= s_start;
					st_q <= lus_pkg::ST_LOAD;
				end
				lus_pkg::ST_LOAD: begin
					if (s_q == s_lim) begin
						st_q <= use_div ? lus_pkg::ST_DVS : lus_pkg::ST_WR;
					end else begin
						st_q <= lus_pkg::ST_RD;
					end
				end
				lus_pkg::ST_RD: begin
					st_q <= lus_pkg::ST_MUL;
				end
				lus_pkg::ST_MUL: begin
					st_q <= lus_pkg::ST_ACC;
				end
				lus_pkg::ST_ACC: begin
					ovf_q <= ovf_q | term.ovf | diff.ovf;
					s_q   <= s_nxt;
					if (s_nxt == s_lim) begin
						st_q <= use_div ? lus_pkg::ST_DVS : lus_pkg::ST_WR;
					end else begin
						st_q <= lus_pkg::ST_RD;
					end
				end
				lus_pkg::ST_DVS: begin
					if (piv_q == '0) begin
						sing_q <= 1'b1;
						st_q   <= lus_pkg::ST_WR;
					end else begin
						dcnt_q <= lus_pkg::DCNT_W'(lus_pkg::DIV_BITS);
						st_q   <= lus_pkg::ST_DIV;
					end
				end
				lus_pkg::ST_DIV: begin
					dcnt_q <= dcnt_q - lus_pkg::DCNT_W'(1);
					if (dcnt_q == lus_pkg::DCNT_W'(1)) begin
						st_q <= lus_pkg::ST_DVF;
					end
				end
				lus_pkg::ST_DVF: begin
					ovf_q <= ovf_q | dvf_ovf;
					st_q  <= lus_pkg::ST_WR;
				end
				lus_pkg::ST_WR: begin
					// the last back-substituted element starts the emit phase
					if ((ph_q == lus_pkg::PH_X) && (r_q == '0)) begin
						st_q <= lus_pkg::ST_ERD;
					end else begin
						st_q <= lus_pkg::ST_INIT;
					end
					case (ph_q)
						lus_pkg::PH_L: begin
							if (r_q != LAST_IDX) begin
								r_q <= r_q + lus_pkg::CNT_W'(1);
							end else if (k_q != LAST_IDX) begin
								ph_q <= lus_pkg::PH_U;
								r_q  <= k_q + lus_pkg::CNT_W'(1);
							end else begin
								ph_q <= lus_pkg::PH_Y;
								r_q  <= '0;
							end
						end
						lus_pkg::PH_U: begin
							if (r_q != LAST_IDX) begin
								r_q <= r_q + lus_pkg::CNT_W'(1);
							end else begin
								ph_q <= lus_pkg::PH_L;
								k_q  <= k_q + lus_pkg::CNT_W'(1);
								r_q  <= k_q + lus_pkg::CNT_W'(1);
							end
						end
						lus_pkg::PH_Y: begin
							if (r_q != LAST_IDX) begin
								r_q <= r_q + lus_pkg::CNT_W'(1);
							end else begin
								ph_q <= lus_pkg::PH_X;
								r_q  <= LAST_IDX;
							end
						end
						default: begin
							if (r_q != '0) begin
								r_q <= r_q - lus_pkg::CNT_W'(1);
							end else begin
								e_q <= '0;
							end
						end
					endcase
				end
				lus_pkg::ST_ERD: begin
					st_q <= lus_pkg::ST_ELD;
				end
				lus_pkg::ST_ELD: begin
					out_valid_q <= 1'b1;
					st_q        <= lus_pkg::ST_EWT;
				end
				lus_pkg::ST_EWT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (e_q == LAST_IDX) begin
							st_q <= lus_pkg::ST_IDLE;
						end else begin
							e_q  <= e_q + lus_pkg::CNT_W'(1);
							st_q <= lus_pkg::ST_ERD;
						end
					end
				end
				default: begin
					st_q <= lus_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			lus_pkg::ST_LOAD: begin
				acc_q <= rdata_a;
				piv_q <= rdata_b;
			end
			lus_pkg::ST_MUL: begin
				prod_s2 <= lus_pkg::PROD_W'(rdata_a) * lus_pkg::PROD_W'(rdata_b);
			end
			lus_pkg::ST_ACC: begin
				acc_q <= diff.val;
			end
			lus_pkg::ST_DVS: begin
				if (piv_q == '0) begin
					acc_q <= '0;
				end else begin
					dvd_q <= {lus_pkg::mag(acc_q), {lus_pkg::FRAC_BITS{1'b0}}};
					rem_q <= '0;
					dsr_q <= lus_pkg::mag(piv_q);
					neg_q <= acc_q[lus_pkg::WORD_W-1] ^ piv_q[lus_pkg::WORD_W-1];
				end
			end
			lus_pkg::ST_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[lus_pkg::DIV_BITS-2:0], q_bit};
			end
			lus_pkg::ST_DVF: begin
				acc_q <= dvf_val;
			end
			lus_pkg::ST_ELD: begin
				sol_q  <= rdata_a;
				uidx_q <= lus_pkg::UIDX_W'(e_q);
				last_q <= (e_q == LAST_IDX);
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign unknown_index = uidx_q;
	assign solution      = sol_q;
	assign last          = last_q;
	assign singular      = sing_q;
	assign overflow      = ovf_q;

`ifndef NO_ASSERTIONS
	a_out_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (st_q == lus_pkg::ST_EWT))
		else $error("result shown outside the wait state");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid_q)
		else $error("input taken while a result is pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && last_q) |=> (st_q == lus_pkg::ST_IDLE))
		else $error("run did not end after the last solution");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lus_pkg::ST_DIV) |-> (dcnt_q != '0))
		else $error("divider running with an empty count");

	a_wr_next: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lus_pkg::ST_WR) |=> (st_q == lus_pkg::ST_INIT || st_q == lus_pkg::ST_ERD))
		else $error("bad step after a write-back");
`endif

endmodule
`default_nettype wire

>>> test/lu_solve_3x3_test.sv
`timescale 1ns / 1ps
module lu_solve_3x3_test;

	localparam int ONE_Q = 1 << lus_pkg::FRAC_BITS;

	// one emitted solution as the block should present it
	typedef struct {
		logic [lus_pkg::UIDX_W-1:0] idx;
		int                         sol;
		bit                         last;
		bit                         sing;
		bit                         ovf;
	} solution_t;

	// mirrors the block: stores, crout factors and the solution queue
	class lu_solution_board;
		int        coef[lus_pkg::MAT_SIZE];
		int        rhs[lus_pkg::ORDER];
		int        lf[lus_pkg::MAT_SIZE];
		int        uf[lus_pkg::MAT_SIZE];
		int        fwd[lus_pkg::ORDER];
		bit        ovf_hit;
		bit        sing_hit;
		solution_t pending_solutions[$];
		int        errors;

		function int sat(longint v);
			if (v > 64'sd2147483647) begin
				ovf_hit = 1;
				return 32'h7fff_ffff;
			end
			if (v < -64'sd2147483648) begin
				ovf_hit = 1;
				return 32'h8000_0000;
			end
			return int'(v);
		endfunction

		// floor shift of the exact product
		function int qmul(int a, int b);
			longint p;
			p = longint'(a) * longint'(b);
			return sat(p >>> lus_pkg::FRAC_BITS);
		endfunction

		// truncating divide; a zero pivot gives zero
		function int qdiv(int a, int b);
			if (b == 0) begin
				sing_hit = 1;
				return 0;
			end
			return sat((longint'(a) * longint'(ONE_Q)) / longint'(b));
		endfunction

		function int qsub(int a, int b);
			return sat(longint'(a) - longint'(b));
		endfunction

		function void note_request(logic [lus_pkg::SLOT_W-1:0] s, int v, bit do_solve);
			int        acc;
			int        x[lus_pkg::ORDER];
			solution_t r;
			if (s < lus_pkg::MAT_SIZE)
				coef[s] = v;
			else if (s < lus_pkg::MAT_SIZE + lus_pkg::ORDER)
				rhs[s - lus_pkg::MAT_SIZE] = v;
			if (!do_solve)
				return;
			ovf_hit  = 0;
			sing_hit = 0;
			for (int k = 0; k < lus_pkg::ORDER; k++) begin
				for (int i = k; i < lus_pkg::ORDER; i++) begin
					acc = coef[i*lus_pkg::ORDER + k];
					for (int m = 0; m < k; m++)
						acc = qsub(acc, qmul(lf[i*lus_pkg::ORDER + m],
							uf[m*lus_pkg::ORDER + k]));
					lf[i*lus_pkg::ORDER + k] = acc;
				end
				uf[k*lus_pkg::ORDER + k] = ONE_Q;
				for (int j = k + 1; j < lus_pkg::ORDER; j++) begin
					acc = coef[k*lus_pkg::ORDER + j];
					for (int m = 0; m < k; m++)
						acc = qsub(acc, qmul(lf[k*lus_pkg::ORDER + m],
							uf[m*lus_pkg::ORDER + j]));
					uf[k*lus_pkg::ORDER + j] = qdiv(acc, lf[k*lus_pkg::ORDER + k]);
				end
			end
			for (int i = 0; i < lus_pkg::ORDER; i++) begin
				acc = rhs[i];
				for (int m = 0; m < i; m++)
					acc = qsub(acc, qmul(lf[i*lus_pkg::ORDER + m], fwd[m]));
				fwd[i] = qdiv(acc, lf[i*lus_pkg::ORDER + i]);
			end
			for (int i = lus_pkg::ORDER - 1; i >= 0; i--) begin
				acc = fwd[i];
				for (int m = i + 1; m < lus_pkg::ORDER; m++)
					acc = qsub(acc, qmul(uf[i*lus_pkg::ORDER + m], x[m]));
				x[i] = acc;
			end
			for (int i = 0; i < lus_pkg::ORDER; i++) begin
				r.idx  = lus_pkg::UIDX_W'(i);
				r.sol  = x[i];
				r.last = (i == lus_pkg::ORDER - 1);
				r.sing = sing_hit;
				r.ovf  = ovf_hit;
				pending_solutions.push_back(r);
			end
		endfunction

		function void check_solution(logic [lus_pkg::UIDX_W-1:0] idx, int sol, bit lst,
				bit sng, bit ovf);
			solution_t e;
			if (pending_solutions.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected solution idx=%0d sol=%h", idx, sol);
				return;
			end
			e = pending_solutions.pop_front();
			if (e.idx !== idx || e.sol !== sol || e.last !== lst || e.sing !== sng
					|| e.ovf !== ovf) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp idx=%0d sol=%h last=%b sing=%b ovf=%b",
						e.idx, e.sol, e.last, e.sing, e.ovf,
						", got idx=%0d sol=%h last=%b sing=%b ovf=%b",
						idx, sol, lst, sng, ovf);
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [lus_pkg::SLOT_W-1:0]        slot = '0;
	logic signed [lus_pkg::WORD_W-1:0] value = '0;
	logic                              solve_req = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [lus_pkg::UIDX_W-1:0]        unknown_index;
	logic signed [lus_pkg::WORD_W-1:0] solution;
	logic                              last;
	logic                              singular;
	logic                              overflow;

	lu_solution_board board = new();
	bit               calm = 0;    // no idling on either side while set
	bit               hold_rq = 0; // asks the receiver for one long hold-off
	int               sent = 0;

	lu_solve_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.slot(slot), .value(value), .solve_req(solve_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.unknown_index(unknown_index), .solution(solution), .last(last),
		.singular(singular), .overflow(overflow)
	);

	always #5 clk = ~clk;

	function automatic int idle_cycles();
		if (calm || $urandom_range(0, 4) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	// one request: random gap, then hold valid until taken
	task automatic send_request(input logic [lus_pkg::SLOT_W-1:0] s, input int v,
			input bit do_solve);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		slot      <= s;
		value     <= v;
		solve_req <= do_solve;
		do @(posedge clk); while (!in_ready);
		board.note_request(s, v, do_solve);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_solutions.size() != 0) @(posedge clk);
	endtask

	// mixed values: extremes, zero, full range and modest magnitudes
	function automatic int rand_value();
		int m;
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3, 4: return $urandom;
			default: begin
				m = $urandom_range(0, 4 * ONE_Q);
				return $urandom_range(0, 1) ? -m : m;
			end
		endcase
	endfunction

	// well-conditioned system: strong diagonal, small off-diagonal terms
	function automatic int sane_value(int s);
		int m;
		if (s < lus_pkg::MAT_SIZE && (s % (lus_pkg::ORDER + 1)) == 0)
			m = $urandom_range(4 * ONE_Q, 8 * ONE_Q);
		else
			m = $urandom_range(0, ONE_Q);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_rq) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_rq = 0;
			end
			n = idle_cycles();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_solution(unknown_index, solution, last, singular, overflow);
		end
	end

	// stimulus
	initial begin
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry written first: twice identity, rhs of 0, 1, 2
		for (int s = 0; s < lus_pkg::MAT_SIZE + lus_pkg::ORDER; s++)
			send_request(lus_pkg::SLOT_W'(s),
				s < lus_pkg::MAT_SIZE ? ((s % (lus_pkg::ORDER + 1)) == 0 ? 2 * ONE_Q : 0)
				: (s - lus_pkg::MAT_SIZE) * ONE_Q,
				s == lus_pkg::MAT_SIZE + lus_pkg::ORDER - 1);
		// zero pivot
		send_request(lus_pkg::SLOT_W'(0), 0, 1);
		send_request(lus_pkg::SLOT_W'(0), 2 * ONE_Q, 0);
		// extreme values in a coefficient and the right-hand side
		send_request(lus_pkg::SLOT_W'(4), 32'h7fff_ffff, 0);
		send_request(lus_pkg::SLOT_W'(9), 32'h8000_0000, 0);
		send_request(lus_pkg::SLOT_W'(10), 32'h7fff_ffff, 1);
		// alternating bit patterns
		send_request(lus_pkg::SLOT_W'(9), 32'haaaa_aaaa, 0);
		send_request(lus_pkg::SLOT_W'(10), 32'h5555_5555, 1);
		// slots beyond the stores, with and without a solve
		send_request(lus_pkg::SLOT_W'(12), 32'h1234_5678, 1);
		send_request(lus_pkg::SLOT_W'(15), -1, 0);
		send_request(lus_pkg::SLOT_W'(13), 0, 1);
		send_request(lus_pkg::SLOT_W'(14), 32'h8000_0000, 0);

		// long receiver hold-off while requests keep coming
		wait_drained();
		hold_rq = 1;
		send_request(lus_pkg::SLOT_W'(5), ONE_Q, 1);
		for (int i = 0; i < 4; i++)
			send_request(lus_pkg::SLOT_W'($urandom_range(0, 15)), rand_value(), i == 3);
		// sender pauses until the block has nothing left to give
		wait_drained();

		while (sent < 430) begin
			calm = (sent > 200 && sent < 250);
			k = $urandom_range(0, 9);
			if (k < 3) begin
				// whole new well-conditioned system, then solve
				for (int s = 0; s < lus_pkg::MAT_SIZE + lus_pkg::ORDER; s++)
					send_request(lus_pkg::SLOT_W'(s), sane_value(s),
						s == lus_pkg::MAT_SIZE + lus_pkg::ORDER - 1);
			end else if (k < 8) begin
				// a few random stores then a solve
				repeat ($urandom_range(0, 5))
					send_request(lus_pkg::SLOT_W'($urandom_range(0, 15)), rand_value(), 0);
				send_request(lus_pkg::SLOT_W'($urandom_range(0, 15)), rand_value(), 1);
			end else begin
				// noise
				send_request(lus_pkg::SLOT_W'($urandom), $urandom, $urandom_range(0, 3) == 0);
			end
		end
		calm = 0;

		wait_drained();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending_solutions.size() == 0)
			$display("lu_solve_3x3 test passed");
		else
			$display("lu_solve_3x3 test failed");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("lu_solve_3x3 test failed");
		$finish;
	end

endmodule
